@@ src/rtss_pkg.sv @@
// Shared types and constants for the reactive target seek steering unit.
package rtss_pkg;

    // Item kinds carried on the input tuser bit
    localparam logic OP_TARGET = 1'b0;
    localparam logic OP_RANGE  = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] REG_AIM_HEADING   = 3'd0;
    localparam logic [2:0] REG_VAR_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_HYSTERESIS    = 3'd2;
    localparam logic [2:0] REG_TURN_LIMIT    = 3'd3;
    localparam logic [2:0] REG_TURN_GAIN     = 3'd4;
    localparam logic [2:0] REG_FORWARD_SPEED = 3'd5;
    localparam logic [2:0] REG_OBSTACLE_DIST = 3'd6;
    localparam logic [2:0] REG_SPIN_SPEED    = 3'd7;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 17;

    // Fixed arithmetic constants
    localparam logic signed [18:0] ANGLE_SCALE   = 19'sd234684; // 180/(16*pi) in Q16
    localparam logic [15:0]        NEAR_LIMIT_MM = 16'd400;
    localparam logic [13:0]        DIV_CAP       = 14'd10240;
    localparam logic [15:0]        LFSR_SEED     = 16'hACE1;
    localparam int                 DIV_STEPS     = 27;
    localparam int                 QUEUE_DEPTH   = 2;

    // Configuration register file contents
    typedef struct packed {
        logic signed [16:0] aim_heading;
        logic [15:0]        var_threshold;
        logic [15:0]        hysteresis;
        logic [14:0]        turn_limit;
        logic [15:0]        turn_gain;
        logic [14:0]        forward_speed;
        logic [15:0]        obstacle_dist;
        logic [14:0]        spin_speed;
    } t_cfg;

    // One finished scan handed from the front end to the back end
    typedef struct packed {
        logic [15:0]        min_range;
        logic               visible;
        logic signed [16:0] angle;
    } t_scan_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DIV
    } t_back_state;

endpackage

@@ src/rtss_front.sv @@
// Front end: takes input transfers, tracks the target and the scan minimum.
module rtss_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_opcode,
    input  logic [15:0]          i_range_mm,
    input  logic                 i_last_sample,
    input  logic signed [15:0]   i_target_x_mm,
    input  logic signed [14:0]   i_target_theta,
    output logic                 o_push,
    output rtss_pkg::t_scan_entry o_entry
);
    import rtss_pkg::*;

    logic               r_visible;
    logic signed [16:0] r_angle;
    logic [15:0]        r_min;

    logic signed [16:0] x_off;
    logic               absent;
    logic signed [33:0] angle_prod;
    logic signed [33:0] angle_rnd;
    logic [15:0]        min_now;

    // Target is absent when x lies within 20 mm of -1000 mm
    assign x_off  = 17'(i_target_x_mm) + 17'sd1000;
    assign absent = (x_off > -17'sd20) && (x_off < 17'sd20);

    // Q2.12 radians to Q8.8 degrees, rounded half up
    assign angle_prod = 34'(i_target_theta) * 34'(ANGLE_SCALE);
    assign angle_rnd  = angle_prod + 34'sd32768;

    assign min_now = (i_range_mm < r_min) ? i_range_mm : r_min;

    // Hand a finished scan to the queue
    assign o_push          = i_accept && (i_opcode == OP_RANGE) && i_last_sample;
    assign o_entry.min_range = min_now;
    assign o_entry.visible   = r_visible;
    assign o_entry.angle     = r_angle;

    // Update target state and the running minimum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visible <= 1'b0;
            r_angle   <= '0;
            r_min     <= '1;
        end else if (i_accept) begin
            if (i_opcode == OP_TARGET) begin
                if (absent) begin
                    r_visible <= 1'b0;
                end else begin
                    r_visible <= 1'b1;
                    r_angle   <= angle_rnd[32:16];
                end
            end else begin
                r_min <= i_last_sample ? 16'hFFFF : min_now;
            end
        end
    end

endmodule

@@ src/rtss_queue.sv @@
// Short queue of finished scans between the front and back ends.
module rtss_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  rtss_pkg::t_scan_entry i_entry,
    input  logic                  i_pop,
    output rtss_pkg::t_scan_entry o_entry,
    output logic                  o_full,
    output logic                  o_empty
);
    import rtss_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_scan_entry        r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Advance pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from an empty queue");

endmodule

@@ src/rtss_back.sv @@
// Back end: steering decision, speed divider and the result register.
module rtss_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rtss_pkg::t_cfg        i_cfg,
    input  rtss_pkg::t_scan_entry i_entry,
    input  logic                  i_empty,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [15:0]    o_linear_speed,
    output logic signed [15:0]    o_angular_speed
);
    import rtss_pkg::*;

    t_back_state r_state, n_state;
    t_scan_entry r_job, n_job;
    logic        r_corr, n_corr;
    logic        r_spin, n_spin;
    logic        r_spin_neg, n_spin_neg;
    logic [15:0] r_lfsr, n_lfsr;
    logic signed [34:0] r_prod, n_prod;
    logic [13:0] r_rem, n_rem;
    logic [26:0] r_quo, n_quo;
    logic [13:0] r_dv, n_dv;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_out_valid, n_out_valid;
    logic signed [15:0] r_lin, n_lin;
    logic signed [15:0] r_ang, n_ang;

    logic signed [17:0] var_v;
    logic [17:0]        var_abs;
    logic signed [18:0] thr_low;
    logic               corr_next;
    logic [14:0]        trial;
    logic               trial_ge;
    logic [26:0]        quo_step;
    logic signed [18:0] turn_t;
    logic signed [18:0] turn_min;
    logic               lfsr_fb;

    // Angle error and its magnitude
    assign var_v   = 18'(i_cfg.aim_heading) - 18'(r_job.angle);
    assign var_abs = var_v[17] ? 18'(-var_v) : 18'(var_v);
    assign thr_low = $signed({3'b000, i_cfg.var_threshold})
                   - $signed({3'b000, i_cfg.hysteresis});

    // Hysteretic correcting flag
    always_comb begin
        corr_next = r_corr;
        if (var_abs > {2'b00, i_cfg.var_threshold}) begin
            corr_next = 1'b1;
        end
        if (($signed({1'b0, var_abs}) < thr_low) || (r_job.min_range < NEAR_LIMIT_MM)) begin
            corr_next = 1'b0;
        end
    end

    // One restoring divider step
    assign trial    = {r_rem, r_quo[26]};
    assign trial_ge = (trial >= {1'b0, r_dv});
    assign quo_step = {r_quo[25:0], trial_ge};

    // Turn command with upper clamp, then saturation below
    assign turn_t   = r_prod[34:16];
    assign turn_min = (turn_t < $signed({4'b0000, i_cfg.turn_limit}))
                    ? turn_t : $signed({4'b0000, i_cfg.turn_limit});

    assign lfsr_fb = r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5];

    assign o_valid         = r_out_valid;
    assign o_linear_speed  = r_lin;
    assign o_angular_speed = r_ang;

    // Hold the state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_corr      <= 1'b0;
            r_spin      <= 1'b0;
            r_spin_neg  <= 1'b0;
            r_lfsr      <= LFSR_SEED;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_corr      <= n_corr;
            r_spin      <= n_spin;
            r_spin_neg  <= n_spin_neg;
            r_lfsr      <= n_lfsr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_dv   <= n_dv;
        r_cnt  <= n_cnt;
        r_lin  <= n_lin;
        r_ang  <= n_ang;
    end

    // Next state and datapath
    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_corr      = r_corr;
        n_spin      = r_spin;
        n_spin_neg  = r_spin_neg;
        n_lfsr      = r_lfsr;
        n_prod      = r_prod;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_dv        = r_dv;
        n_cnt       = r_cnt;
        n_lin       = r_lin;
        n_ang       = r_ang;
        n_out_valid = r_out_valid && !i_ready;
        o_pop       = 1'b0;

        case (r_state)
            S_IDLE: begin
                // Take the next scan once the result register is free
                if (!i_empty && !r_out_valid) begin
                    o_pop   = 1'b1;
                    n_job   = i_entry;
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_prod = $signed({1'b0, i_cfg.turn_gain}) * 35'(var_v);
                if (r_job.visible) begin
                    n_corr = corr_next;
                    if (corr_next) begin
                        // Start the divide of forward_speed * 2560 by the capped error
                        n_rem   = '0;
                        n_quo   = 27'({i_cfg.forward_speed, 11'b0})
                                + 27'({i_cfg.forward_speed, 9'b0});
                        if (var_abs >= 18'(DIV_CAP)) begin
                            n_dv = DIV_CAP;
                        end else if (var_abs == '0) begin
                            n_dv = 14'd1;
                        end else begin
                            n_dv = var_abs[13:0];
                        end
                        n_cnt   = 5'(DIV_STEPS - 1);
                        n_state = S_DIV;
                    end else begin
                        n_lin       = $signed({1'b0, i_cfg.forward_speed});
                        n_ang       = '0;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    if (r_job.min_range > i_cfg.obstacle_dist) begin
                        // Clear path: drive ahead at half speed
                        n_lin  = $signed({2'b00, i_cfg.forward_speed[14:1]});
                        n_ang  = '0;
                        n_spin = 1'b0;
                    end else begin
                        // Blocked: spin, picking a direction once per spin
                        n_lin = '0;
                        if (!r_spin) begin
                            n_lfsr     = {lfsr_fb, r_lfsr[15:1]};
                            n_spin_neg = r_lfsr[1];
                            n_spin     = 1'b1;
                        end
                        n_ang = n_spin_neg ? -$signed({1'b0, i_cfg.spin_speed})
                                           :  $signed({1'b0, i_cfg.spin_speed});
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_DIV: begin
                n_rem = trial_ge ? 14'(trial - {1'b0, r_dv}) : trial[13:0];
                n_quo = quo_step;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_lin = (quo_step > 27'd32767) ? 16'sd32767 : $signed(quo_step[15:0]);
                    n_ang = (turn_min < -19'sd32768) ? -16'sd32768 : turn_min[15:0];
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_div_needs_corr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> r_corr)
        else $error("divider running without correction");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_CALC || $past(r_state) == S_DIV))
        else $error("result raised outside calc or divide");

    a_spin_draws: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_spin) |-> (r_lfsr != $past(r_lfsr)))
        else $error("spin started without an LFSR draw");

endmodule

@@ src/reactive_target_seek_steering_unit.sv @@
// Top level: configuration registers, front end, scan queue and back end.
// Input transfers are accepted at one per cycle whenever the two-entry scan queue has room.
// Target observations and range samples take effect in the cycle after their transfer.
// A last range sample queues a scan; the back end takes it once the result register is free,
// and while correcting runs the 27-step serial divider before it registers the result.
// Synchronous active-low reset restores register defaults, empties the queue, seeds the LFSR.
module reactive_target_seek_steering_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [47:0]                     i_s_axis_tdata,   // range_mm, target_x_mm, target_theta, pad
    input  logic                            i_s_axis_tuser,   // opcode
    input  logic                            i_s_axis_tlast,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [31:0]                     o_m_axis_tdata,   // linear_speed, angular_speed
    input  logic                            i_cfg_we,
    input  logic [rtss_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [16:0]                     i_cfg_wdata
);
    import rtss_pkg::*;

    t_cfg        r_cfg;
    t_scan_entry push_entry;
    t_scan_entry head_entry;
    logic        accept;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    logic signed [15:0] lin;
    logic signed [15:0] ang;

    assign o_s_axis_tready = !q_full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tdata  = {ang, lin};

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.aim_heading   <= '0;
            r_cfg.var_threshold <= 16'd2560;
            r_cfg.hysteresis    <= 16'd1280;
            r_cfg.turn_limit    <= 15'd1000;
            r_cfg.turn_gain     <= 16'd256;
            r_cfg.forward_speed <= 15'd200;
            r_cfg.obstacle_dist <= 16'd500;
            r_cfg.spin_speed    <= 15'd500;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_AIM_HEADING:   r_cfg.aim_heading   <= i_cfg_wdata;
                REG_VAR_THRESHOLD: r_cfg.var_threshold <= i_cfg_wdata[15:0];
                REG_HYSTERESIS:    r_cfg.hysteresis    <= i_cfg_wdata[15:0];
                REG_TURN_LIMIT:    r_cfg.turn_limit    <= i_cfg_wdata[14:0];
                REG_TURN_GAIN:     r_cfg.turn_gain     <= i_cfg_wdata[15:0];
                REG_FORWARD_SPEED: r_cfg.forward_speed <= i_cfg_wdata[14:0];
                REG_OBSTACLE_DIST: r_cfg.obstacle_dist <= i_cfg_wdata[15:0];
                REG_SPIN_SPEED:    r_cfg.spin_speed    <= i_cfg_wdata[14:0];
                default: begin
                end
            endcase
        end
    end

    rtss_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_opcode       (i_s_axis_tuser),
        .i_range_mm     (i_s_axis_tdata[15:0]),
        .i_last_sample  (i_s_axis_tlast),
        .i_target_x_mm  ($signed(i_s_axis_tdata[31:16])),
        .i_target_theta ($signed(i_s_axis_tdata[46:32])),
        .o_push         (push),
        .o_entry        (push_entry)
    );

    rtss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    rtss_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_entry         (head_entry),
        .i_empty         (q_empty),
        .o_pop           (pop),
        .o_valid         (o_m_axis_tvalid),
        .i_ready         (i_m_axis_tready),
        .o_linear_speed  (lin),
        .o_angular_speed (ang)
    );

endmodule

@@ bench/tb_reactive_target_seek_steering_unit.sv @@
// Self-checking testbench for the reactive target seek steering unit.
`timescale 1ns / 100ps

module tb_reactive_target_seek_steering_unit;
    import rtss_pkg::*;

    localparam longint DEG_PER_RAD_Q16 = 234684;  // 180/(16*pi) in Q16
    localparam longint CLOSE_RANGE_MM  = 400;
    localparam longint SPAN_CAP        = 10240;
    localparam longint SPEED_SCALE     = 2560;
    localparam int     SETTLE_CYCLES   = 40;
    localparam int     PHASE_ITEMS     = 125;
    localparam int     NUM_SETTINGS    = 9;
    localparam int     NUM_ROWS        = 26;

    // One input transfer, with an optional hand-written result
    typedef struct {
        logic               op;
        logic [15:0]        rng;
        logic               lst;
        logic signed [15:0] x;
        logic signed [14:0] th;
        logic               typed;
        logic signed [15:0] lin;
        logic signed [15:0] ang;
    } t_xfer;

    typedef struct {
        logic signed [15:0] lin;
        logic signed [15:0] ang;
    } t_steer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata = '0;  // range_mm, target_x_mm, target_theta, pad
    logic        i_s_axis_tuser = OP_TARGET;  // opcode
    logic        i_s_axis_tlast = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;  // linear_speed, angular_speed
    logic        i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    reactive_target_seek_steering_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // Shadow registers and steering state
    longint      cfg_center = 0;
    longint      cfg_thr = 2560;
    longint      cfg_hyst = 1280;
    longint      cfg_turn_limit = 1000;
    longint      cfg_gain = 256;
    longint      cfg_fwd = 200;
    longint      cfg_obs = 500;
    longint      cfg_spin = 500;
    logic        tgt_seen = 1'b0;
    longint      tgt_angle = 0;
    logic        correcting = 1'b0;
    logic        spinning = 1'b0;
    logic        spin_neg = 1'b0;
    logic [15:0] scan_min = 16'hFFFF;
    logic [15:0] spin_lfsr = 16'hACE1;

    t_steer      steer_q[$];
    int          fault_cnt = 0;
    int          items_in = 0;
    int          results_out = 0;

    // Hand-written result attached to the transfer on the bus
    logic               row_typed = 1'b0;
    logic signed [15:0] row_lin = '0;
    logic signed [15:0] row_ang = '0;

    // Directed rows: op, range, last, x, theta, typed, linear, angular
    t_xfer dir_rows [NUM_ROWS] = '{
        '{OP_RANGE,  16'd1000,  1'b1, 16'sd0,      15'sd0,      1'b1, 16'sd100, 16'sd0},
        '{OP_RANGE,  16'd65535, 1'b1, 16'sd0,      15'sd0,      1'b1, 16'sd100, 16'sd0},
        '{OP_RANGE,  16'd0,     1'b1, 16'sd0,      15'sd0,      1'b1, 16'sd0,   16'sd500},
        '{OP_RANGE,  16'd300,   1'b1, 16'sd0,      15'sd0,      1'b0, 16'sd0,   16'sd0},
        '{OP_RANGE,  16'd501,   1'b1, 16'sd0,      15'sd0,      1'b0, 16'sd0,   16'sd0},
        '{OP_RANGE,  16'd500,   1'b1, 16'sd0,      15'sd0,      1'b0, 16'sd0,   16'sd0},
        '{OP_RANGE,  16'd800,   1'b0, 16'sd0,      15'sd0,      1'b0, 16'sd0,   16'sd0},
        '{OP_RANGE,  16'd40000, 1'b0, -16'sd1000,  15'sd12868,  1'b0, 16'sd0,   16'sd0},
        '{OP_RANGE,  16'd600,   1'b1, 16'sd0,      15'sd0,      1'b0, 16'sd0,   16'sd0},
        '{OP_TARGET, 16'd5,     1'b1, 16'sd0,      15'sd0,      1'b0, 16'sd0,   16'sd0},
        '{OP_RANGE,  16'd1000,  1'b1, 16'sd0,      15'sd0,      1'b1, 16'sd200, 16'sd0},
        '{OP_TARGET, 16'd0,     1'b0, 16'sd0,      15'sd12868,  1'b0, 16'sd0,   16'sd0},
        '{OP_RANGE,  16'd1000,  1'b1, 16'sd0,      15'sd0,      1'b1, 16'sd50,  -16'sd180},
        '{OP_TARGET, 16'd0,     1'b0, -16'sd1000,  15'sd0,      1'b0, 16'sd0,   16'sd0},
        '{OP_RANGE,  16'd2000,  1'b1, 16'sd0,      15'sd0,      1'b0, 16'sd0,   16'sd0},
        '{OP_TARGET, 16'd0,     1'b0, -16'sd1020,  -15'sd12868, 1'b0, 16'sd0,   16'sd0},
        '{OP_RANGE,  16'd1000,  1'b1, 16'sd0,      15'sd0,      1'b1, 16'sd50,  16'sd180},
        '{OP_RANGE,  16'd399,   1'b1, 16'sd0,      15'sd0,      1'b1, 16'sd200, 16'sd0},
        '{OP_TARGET, 16'd0,     1'b0, -16'sd981,   15'sd0,      1'b0, 16'sd0,   16'sd0},
        '{OP_TARGET, 16'd0,     1'b0, -16'sd1019,  15'sd0,      1'b0, 16'sd0,   16'sd0},
        '{OP_RANGE,  16'd700,   1'b1, 16'sd0,      15'sd0,      1'b0, 16'sd0,   16'sd0},
        '{OP_TARGET, 16'd0,     1'b0, -16'sd980,   -15'sd16384, 1'b0, 16'sd0,   16'sd0},
        '{OP_RANGE,  16'd65535, 1'b1, 16'sd0,      15'sd0,      1'b0, 16'sd0,   16'sd0},
        '{OP_TARGET, 16'd65535, 1'b1, 16'sd32767,  15'sd16383,  1'b0, 16'sd0,   16'sd0},
        '{OP_TARGET, 16'd0,     1'b0, -16'sd32768, 15'sd16383,  1'b0, 16'sd0,   16'sd0},
        '{OP_RANGE,  16'd1000,  1'b1, 16'sd0,      15'sd0,      1'b0, 16'sd0,   16'sd0}
    };

    function automatic longint clip16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Advance the steering state by one transfer; report a velocity pair if one is due
    function automatic void predict_steering(input logic op, input logic [15:0] rng,
                                             input logic lst, input logic signed [15:0] x,
                                             input logic signed [14:0] th,
                                             output logic made, output t_steer res);
        longint dx, a, v, av, t, dv, lin, ang, minv;
        logic   fb;
        made = 1'b0;
        res = '{16'sd0, 16'sd0};
        if (op == OP_TARGET) begin
            dx = longint'(x) + 1000;
            if (dx < 0) dx = -dx;
            if (dx < 20) begin
                tgt_seen = 1'b0;
            end else begin
                a = (longint'(th) * DEG_PER_RAD_Q16 + 32768) >>> 16;
                if (a > 65535) a = 65535;
                if (a < -65536) a = -65536;
                tgt_seen = 1'b1;
                tgt_angle = a;
            end
            return;
        end
        if (rng < scan_min) scan_min = rng;
        if (!lst) return;
        minv = longint'(scan_min);
        scan_min = 16'hFFFF;

        if (tgt_seen) begin
            v = cfg_center - tgt_angle;
            av = (v < 0) ? -v : v;
            if (av > cfg_thr) correcting = 1'b1;
            if (av < cfg_thr - cfg_hyst || minv < CLOSE_RANGE_MM) correcting = 1'b0;
            if (correcting) begin
                t = (cfg_gain * v) >>> 16;
                dv = (av < SPAN_CAP) ? av : SPAN_CAP;
                if (dv < 1) dv = 1;
                ang = (t < cfg_turn_limit) ? t : cfg_turn_limit;
                lin = (cfg_fwd * SPEED_SCALE) / dv;
            end else begin
                ang = 0;
                lin = cfg_fwd;
            end
        end else if (minv > cfg_obs) begin
            lin = cfg_fwd >> 1;
            ang = 0;
            spinning = 1'b0;
        end else begin
            // Pick a spin direction once per spin
            if (!spinning) begin
                fb = spin_lfsr[0] ^ spin_lfsr[2] ^ spin_lfsr[3] ^ spin_lfsr[5];
                spin_lfsr = {fb, spin_lfsr[15:1]};
                spin_neg = spin_lfsr[0];
                spinning = 1'b1;
            end
            lin = 0;
            ang = spin_neg ? -cfg_spin : cfg_spin;
        end
        made = 1'b1;
        res.lin = 16'(clip16(lin));
        res.ang = 16'(clip16(ang));
    endfunction

    // Check output transfers, then predict from input transfers
    always @(posedge i_clk) begin : watch_bus
        t_steer got, want, pred;
        logic   made;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                results_out++;
                got.lin = o_m_axis_tdata[15:0];
                got.ang = o_m_axis_tdata[31:16];
                if (steer_q.size() == 0) begin
                    fault_cnt++;
                    $display("%0t: unexpected result linear %0d angular %0d",
                             $time, got.lin, got.ang);
                end else begin
                    want = steer_q.pop_front();
                    if (got.lin !== want.lin) begin
                        fault_cnt++;
                        $display("%0t: linear_speed expected %0d got %0d",
                                 $time, want.lin, got.lin);
                    end
                    if (got.ang !== want.ang) begin
                        fault_cnt++;
                        $display("%0t: angular_speed expected %0d got %0d",
                                 $time, want.ang, got.ang);
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                items_in++;
                predict_steering(i_s_axis_tuser, i_s_axis_tdata[15:0], i_s_axis_tlast,
                                 i_s_axis_tdata[31:16], i_s_axis_tdata[46:32], made, pred);
                if (made) begin
                    if (row_typed) steer_q.push_back('{row_lin, row_ang});
                    else steer_q.push_back(pred);
                end
            end
        end
    end

    // Receiver: random stalls, one calm stretch and one long hold-off
    initial begin : drain_side
        int  hold_left;
        logic held;
        hold_left = 0;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_m_axis_tready = 1'b0;
                hold_left--;
            end else if (!held && items_in >= 400) begin
                held = 1'b1;
                hold_left = 400;
                i_m_axis_tready = 1'b0;
            end else if (results_out >= 150 && results_out < 220) begin
                i_m_axis_tready = 1'b1;
            end else begin
                i_m_axis_tready = ($urandom_range(0, 99) >= 13);
            end
        end
    end

    // Offer one transfer, with random gaps, and hold it until accepted
    task automatic send_item(input t_xfer it);
        @(negedge i_clk);
        while (!(items_in >= 700 && items_in < 820) && $urandom_range(0, 99) < 13) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata = {1'b0, it.th, it.x, it.rng};
        i_s_axis_tuser = it.op;
        i_s_axis_tlast = it.lst;
        row_typed = it.typed;
        row_lin = it.lin;
        row_ang = it.ang;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // Drop valid and wait until every pending velocity pair has come out
    task automatic settle();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (steer_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [16:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_addr = idx;
        i_cfg_wdata = val;
        case (idx)
            REG_AIM_HEADING:   cfg_center = longint'($signed(val));
            REG_VAR_THRESHOLD: cfg_thr = longint'(val[15:0]);
            REG_HYSTERESIS:    cfg_hyst = longint'(val[15:0]);
            REG_TURN_LIMIT:    cfg_turn_limit = longint'(val[14:0]);
            REG_TURN_GAIN:     cfg_gain = longint'(val[15:0]);
            REG_FORWARD_SPEED: cfg_fwd = longint'(val[14:0]);
            REG_OBSTACLE_DIST: cfg_obs = longint'(val[15:0]);
            REG_SPIN_SPEED:    cfg_spin = longint'(val[14:0]);
            default: ;
        endcase
    endtask

    // Load one register setting: zeros, all ones, maxima, a fixed mix, then random
    task automatic load_setting(input int k);
        logic [16:0] v [8];
        case (k)
            1: v = '{17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0};
            2: v = '{17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF,
                     17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF};
            3: v = '{17'd46080, 17'd46080, 17'd46080, 17'd32767,
                     17'd65535, 17'd32767, 17'd65535, 17'd32767};
            4: v = '{17'h1FFFF - 17'd46079, 17'd500, 17'd200, 17'd300,
                     17'd4000, 17'd1000, 17'd800, 17'd3000};
            default: begin
                if ($urandom_range(0, 1) == 0)
                    v[0] = 17'(int'($urandom_range(0, 92160)) - 46080);
                else
                    v[0] = 17'($urandom);
                v[1] = 17'($urandom_range(0, 8000));
                v[2] = 17'($urandom_range(0, 4000));
                v[3] = 17'($urandom_range(0, 32767));
                v[4] = 17'($urandom_range(0, 65535));
                v[5] = 17'($urandom_range(0, 32767));
                v[6] = 17'($urandom_range(0, 2000));
                v[7] = 17'($urandom_range(0, 32767));
            end
        endcase
        write_reg(REG_AIM_HEADING, v[0]);
        write_reg(REG_VAR_THRESHOLD, v[1]);
        write_reg(REG_HYSTERESIS, v[2]);
        write_reg(REG_TURN_LIMIT, v[3]);
        write_reg(REG_TURN_GAIN, v[4]);
        write_reg(REG_FORWARD_SPEED, v[5]);
        write_reg(REG_OBSTACLE_DIST, v[6]);
        write_reg(REG_SPIN_SPEED, v[7]);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Mostly scans of range samples ended by a last sample, with sightings mixed in
    task automatic make_item(output t_xfer it);
        int     k, j;
        longint tc;
        k = $urandom_range(0, 99);
        j = $urandom_range(0, 9);
        it.typed = 1'b0;
        it.lin = '0;
        it.ang = '0;
        it.rng = 16'($urandom);
        it.lst = 1'($urandom);
        it.x = 16'($urandom);
        it.th = 15'($urandom);
        if (k < 20) begin
            it.op = OP_TARGET;
            if (j < 3) it.x = 16'(int'($urandom_range(0, 60)) - 1030);
            else if (j < 5) it.x = 16'(int'($urandom_range(0, 4000)) - 2000);
            if ($urandom_range(0, 1) == 0) begin
                // Aim near the scan center so the error lands around the threshold
                tc = (cfg_center * 65536) / DEG_PER_RAD_Q16
                     + longint'($urandom_range(0, 1600)) - 800;
                if (tc > 16383) tc = 16383;
                if (tc < -16384) tc = -16384;
                it.th = 15'(tc);
            end
        end else begin
            it.op = OP_RANGE;
            if (k >= 25) begin
                it.lst = ($urandom_range(0, 99) < 30);
                if (j < 4) it.rng = 16'($urandom_range(0, 1000));
                else if (j < 6) it.rng = 16'(cfg_obs + $urandom_range(0, 4) - 2);
            end
        end
    endtask

    initial begin : stimulus
        t_xfer it;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < NUM_ROWS; r++) send_item(dir_rows[r]);
        settle();

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            if (p > 0) load_setting(p);
            repeat (PHASE_ITEMS) begin
                make_item(it);
                send_item(it);
            end
            settle();
        end

        if (fault_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
